/* src/tpc_pkg.sv */
// Shared types, constants and helpers of the triangle plane clipper.
// Depends on nothing; used by tpc_div and triangle_plane_clipper.
package tpc_pkg;

    localparam int COORD_W      = 32;
    localparam int FRAC_BITS_DF = 16;
    localparam int NUM_W        = COORD_W + 1;
    localparam int DEN_W        = COORD_W + 2;
    localparam int REM_W        = COORD_W + 3;
    localparam int PADDR_W      = 3;

    localparam logic REG_CLIP_AXIS  = 1'b0;
    localparam logic REG_PLANE_SIDE = 1'b1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COORD_W:0]   t_diff;
    typedef logic signed [COORD_W:0]   t_dist;

    typedef struct packed {
        t_coord vertex0_x;
        t_coord vertex0_y;
        t_coord vertex0_z;
        t_coord vertex0_w;
        t_coord vertex1_x;
        t_coord vertex1_y;
        t_coord vertex1_z;
        t_coord vertex1_w;
        t_coord vertex2_x;
        t_coord vertex2_y;
        t_coord vertex2_z;
        t_coord vertex2_w;
    } t_tri;

    typedef struct packed {
        t_coord     out_x;
        t_coord     out_y;
        t_coord     out_z;
        t_coord     out_w;
        logic [1:0] corner_slot;
        logic       run_last;
    } t_res;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        t_coord w;
    } t_vtx;

    typedef struct packed {
        t_diff x;
        t_diff y;
        t_diff z;
        t_diff w;
    } t_dvec;

    // ni counts inside vertices. For one inside: ia inside, ib and ic outside.
    // For two inside: ia and ic inside, ib outside.
    typedef struct packed {
        logic [1:0] ni;
        logic [1:0] ia;
        logic [1:0] ib;
        logic [1:0] ic;
        logic       flip;
        logic [1:0] lp1;
        logic [1:0] lq1;
    } t_ctl;

    typedef struct packed {
        t_ctl  ctl;
        t_tri  tgl;
        t_dvec diff0;
        t_dvec diff1;
    } t_pipe;

    function automatic logic [1:0] next3(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic t_vtx get_vtx(input t_tri t, input logic [1:0] i);
        t_vtx v;
        case (i)
            2'd0:    v = '{x: t.vertex0_x, y: t.vertex0_y, z: t.vertex0_z, w: t.vertex0_w};
            2'd1:    v = '{x: t.vertex1_x, y: t.vertex1_y, z: t.vertex1_z, w: t.vertex1_w};
            default: v = '{x: t.vertex2_x, y: t.vertex2_y, z: t.vertex2_z, w: t.vertex2_w};
        endcase
        return v;
    endfunction

    function automatic t_coord vtx_coord(input t_vtx v, input logic [1:0] k);
        t_coord c;
        case (k)
            2'd0:    c = v.x;
            2'd1:    c = v.y;
            2'd2:    c = v.z;
            default: c = v.w;
        endcase
        return c;
    endfunction

    function automatic t_diff dvec_coord(input t_dvec d, input logic [1:0] k);
        t_diff c;
        case (k)
            2'd0:    c = d.x;
            2'd1:    c = d.y;
            2'd2:    c = d.z;
            default: c = d.w;
        endcase
        return c;
    endfunction

endpackage

/* src/triangle_plane_clipper.sv */
// Top level of the triangle plane clipper: classification, crossing points, emission.
// Depends on tpc_pkg and tpc_div.
//
// A triangle is taken whenever start is high and busy is low. Results leave one
// vertex per cycle, so a triangle yields three vertices (one triangle), six
// vertices (two triangles) or none when it is culled; the pipeline holds further
// triangles and raises busy only while the emitter is still sending an earlier one.
// The result port cannot be stalled: each vertex is shown for one cycle with
// o_res_strobe.
module triangle_plane_clipper #(
    parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tpc_pkg::t_tri               i_tri,
    output logic                        o_res_strobe,
    output tpc_pkg::t_res               o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tpc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tpc_pkg::*;

    localparam int W  = COORD_W;
    localparam int PW = W + FRAC_BITS + 2;

    // Configuration registers.
    logic [1:0] r_axis;
    logic       r_side;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= AXIS_X + 2'd2;
            r_side <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_CLIP_AXIS) begin
                r_axis <= pwdata[1:0];
            end else begin
                r_side <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_CLIP_AXIS) begin
            prdata = {30'd0, r_axis};
        end else begin
            prdata = {31'd0, r_side};
        end
    end

    // Emitter state, declared early since it gates the pipeline.
    logic       r_busy;
    logic [2:0] r_idx;
    logic [2:0] r_cnt;
    t_vtx       r_list [6];
    logic       last_now;
    logic       adv;

    assign last_now = r_busy && (r_idx == r_cnt - 3'd1);
    assign adv      = !r_busy || last_now;
    assign busy     = !adv;

    // Stage 1: input register.
    logic r_s1_v;
    t_tri r_s1_tgl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_tgl <= i_tri;
        end
    end

    // Stage 2: plane distances and classification.
    t_dist      d [3];
    logic [2:0] outm;
    t_ctl       ctl2;
    logic       r_s2_v;
    t_tri       r_s2_tgl;
    t_dist      r_s2_d [3];
    t_ctl       r_s2_ctl;

    always_comb begin
        t_vtx   v;
        t_coord c;
        for (int i = 0; i < 3; i++) begin
            v = get_vtx(r_s1_tgl, 2'(i));
            if (r_axis == AXIS_X) begin
                c = v.x;
            end else if (r_axis == AXIS_Y) begin
                c = v.y;
            end else begin
                c = v.z;
            end
            if (r_side) begin
                d[i]    = t_dist'(c) - t_dist'(v.w);
                outm[i] = !d[i][W] && (d[i] != '0);
            end else begin
                d[i]    = t_dist'(c) + t_dist'(v.w);
                outm[i] = d[i][W];
            end
        end
    end

    always_comb begin
        ctl2 = '0;
        case (outm)
            3'b000: ctl2.ni = 2'd3;
            3'b110: begin ctl2.ni = 2'd1; ctl2.ia = 2'd0; ctl2.ib = 2'd1; ctl2.ic = 2'd2; end
            3'b101: begin ctl2.ni = 2'd1; ctl2.ia = 2'd1; ctl2.ib = 2'd0; ctl2.ic = 2'd2; end
            3'b011: begin ctl2.ni = 2'd1; ctl2.ia = 2'd2; ctl2.ib = 2'd0; ctl2.ic = 2'd1; end
            3'b001: begin ctl2.ni = 2'd2; ctl2.ia = 2'd1; ctl2.ib = 2'd0; ctl2.ic = 2'd2; end
            3'b010: begin ctl2.ni = 2'd2; ctl2.ia = 2'd0; ctl2.ib = 2'd1; ctl2.ic = 2'd2; end
            3'b100: begin ctl2.ni = 2'd2; ctl2.ia = 2'd0; ctl2.ib = 2'd2; ctl2.ic = 2'd1; end
            default: ctl2.ni = 2'd0;
        endcase
        ctl2.flip = (next3(ctl2.ia) == ctl2.ib);
        // The second crossing edge: outside c to a, or outside b to inside c.
        ctl2.lp1 = (ctl2.ni == 2'd1) ? ctl2.ic : ctl2.ib;
        ctl2.lq1 = (ctl2.ni == 2'd1) ? ctl2.ia : ctl2.ic;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (adv) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_tgl <= r_s1_tgl;
            r_s2_ctl <= ctl2;
            for (int i = 0; i < 3; i++) begin
                r_s2_d[i] <= d[i];
            end
        end
    end

    // Stage 3: divider operands and coordinate differences of both edges.
    logic             r_s3_v;
    t_pipe            r_s3_p;
    logic [NUM_W-1:0] r_s3_num [2];
    logic [DEN_W-1:0] r_s3_den [2];
    logic [NUM_W-1:0] n_num [2];
    logic [DEN_W-1:0] n_den [2];
    t_dvec            n_diff [2];

    always_comb begin
        logic [1:0]               pi;
        logic [1:0]               qi;
        logic signed [DEN_W-1:0]  dd;
        t_dist                    dp;
        t_vtx                     vp;
        t_vtx                     vq;
        t_diff                    df [4];
        for (int l = 0; l < 2; l++) begin
            pi    = (l == 0) ? r_s2_ctl.ib : r_s2_ctl.lp1;
            qi    = (l == 0) ? r_s2_ctl.ia : r_s2_ctl.lq1;
            dp    = r_s2_d[pi];
            dd    = DEN_W'(dp) - DEN_W'(r_s2_d[qi]);
            n_num[l] = dp[W] ? NUM_W'(-dp) : NUM_W'(dp);
            n_den[l] = dd[DEN_W-1] ? DEN_W'(-dd) : DEN_W'(dd);
            vp    = get_vtx(r_s2_tgl, pi);
            vq    = get_vtx(r_s2_tgl, qi);
            for (int k = 0; k < 4; k++) begin
                df[k] = t_diff'(vtx_coord(vq, 2'(k))) - t_diff'(vtx_coord(vp, 2'(k)));
            end
            n_diff[l] = '{x: df[0], y: df[1], z: df[2], w: df[3]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (adv) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_p <= '{ctl: r_s2_ctl, tgl: r_s2_tgl, diff0: n_diff[0], diff1: n_diff[1]};
            for (int l = 0; l < 2; l++) begin
                r_s3_num[l] <= n_num[l];
                r_s3_den[l] <= n_den[l];
            end
        end
    end

    // Divider stages, with the item's data delayed alongside.
    logic [FRAC_BITS-1:0] tq [2];
    t_pipe                r_dl [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_dv;

    for (genvar l = 0; l < 2; l++) begin : g_div
        tpc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (r_s3_num[l]),
            .i_den (r_s3_den[l]),
            .o_t   (tq[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (adv) begin
            r_dv <= {r_dv[FRAC_BITS-2:0], r_s3_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dl[0] <= r_s3_p;
            for (int s = 1; s < FRAC_BITS; s++) begin
                r_dl[s] <= r_dl[s-1];
            end
        end
    end

    // Multiply stage: (q - p) * t for both edges, all four coordinates.
    logic                 r_mul_v;
    t_pipe                r_mul_p;
    logic signed [PW-1:0] r_mul_prod [2][4];
    logic signed [PW-1:0] n_prod [2][4];

    always_comb begin
        logic signed [FRAC_BITS:0] tv;
        t_dvec                     dv;
        for (int l = 0; l < 2; l++) begin
            tv = signed'({1'b0, tq[l]});
            dv = (l == 0) ? r_dl[FRAC_BITS-1].diff0 : r_dl[FRAC_BITS-1].diff1;
            for (int k = 0; k < 4; k++) begin
                n_prod[l][k] = dvec_coord(dv, 2'(k)) * tv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
        end else if (adv) begin
            r_mul_v <= r_dv[FRAC_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mul_p <= r_dl[FRAC_BITS-1];
            for (int l = 0; l < 2; l++) begin
                for (int k = 0; k < 4; k++) begin
                    r_mul_prod[l][k] <= n_prod[l][k];
                end
            end
        end
    end

    // Add stage: p plus the floored scaled product, saturated.
    logic  r_add_v;
    t_ctl  r_add_ctl;
    t_tri  r_add_tgl;
    t_vtx  r_add_l [2];
    t_vtx  n_l [2];

    always_comb begin
        t_vtx                 vp;
        t_coord               p;
        logic signed [PW-1:0] sh;
        logic signed [W+1:0]  s;
        t_coord               res [4];
        for (int l = 0; l < 2; l++) begin
            vp = get_vtx(r_mul_p.tgl, (l == 0) ? r_mul_p.ctl.ib : r_mul_p.ctl.lp1);
            for (int k = 0; k < 4; k++) begin
                p  = vtx_coord(vp, 2'(k));
                sh = r_mul_prod[l][k] >>> FRAC_BITS;
                s  = {{2{p[W-1]}}, p} + sh[W+1:0];
                if ((s[W+1:W-1] == 3'b000) || (s[W+1:W-1] == 3'b111)) begin
                    res[k] = s[W-1:0];
                end else if (!s[W+1]) begin
                    res[k] = {1'b0, {(W-1){1'b1}}};
                end else begin
                    res[k] = {1'b1, {(W-1){1'b0}}};
                end
            end
            n_l[l] = '{x: res[0], y: res[1], z: res[2], w: res[3]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_v <= 1'b0;
        end else if (adv) begin
            r_add_v <= r_mul_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_add_ctl <= r_mul_p.ctl;
            r_add_tgl <= r_mul_p.tgl;
            r_add_l[0] <= n_l[0];
            r_add_l[1] <= n_l[1];
        end
    end

    // Emission list for the triangle in the add stage.
    t_vtx       lst [6];
    logic [2:0] lst_cnt;
    logic       load;

    always_comb begin
        t_vtx va;
        t_vtx vc;
        va = get_vtx(r_add_tgl, r_add_ctl.ia);
        vc = get_vtx(r_add_tgl, r_add_ctl.ic);
        for (int j = 0; j < 6; j++) begin
            lst[j] = va;
        end
        lst_cnt = 3'd0;
        case (r_add_ctl.ni)
            2'd3: begin
                lst_cnt = 3'd3;
                lst[0]  = get_vtx(r_add_tgl, 2'd0);
                lst[1]  = get_vtx(r_add_tgl, 2'd1);
                lst[2]  = get_vtx(r_add_tgl, 2'd2);
            end
            2'd1: begin
                lst_cnt = 3'd3;
                lst[1]  = r_add_ctl.flip ? r_add_l[0] : r_add_l[1];
                lst[2]  = r_add_ctl.flip ? r_add_l[1] : r_add_l[0];
            end
            2'd2: begin
                lst_cnt = 3'd6;
                lst[4]  = r_add_l[1];
                if (r_add_ctl.flip) begin
                    lst[1] = r_add_l[0];
                    lst[2] = r_add_l[1];
                    lst[5] = vc;
                end else begin
                    lst[1] = vc;
                    lst[2] = r_add_l[1];
                    lst[5] = r_add_l[0];
                end
            end
            default: lst_cnt = 3'd0;
        endcase
    end

    assign load = adv && r_add_v && (lst_cnt != 3'd0);

    // Emitter: one vertex per cycle into the output register.
    logic r_strobe;
    t_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_busy;
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_cnt  <= lst_cnt;
            end else if (r_busy) begin
                if (last_now) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int j = 0; j < 6; j++) begin
                r_list[j] <= lst[j];
            end
        end
        r_res.out_x       <= r_list[r_idx].x;
        r_res.out_y       <= r_list[r_idx].y;
        r_res.out_z       <= r_list[r_idx].z;
        r_res.out_w       <= r_list[r_idx].w;
        r_res.corner_slot <= (r_idx < 3'd3) ? r_idx[1:0] : 2'(r_idx - 3'd3);
        r_res.run_last    <= last_now;
    end

    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

    // A result only follows a cycle in which the emitter was sending.
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(r_busy))
        else $error("result strobe without an active emission");

    // Vertices of one triangle come out in consecutive cycles.
    a_corner_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.corner_slot != 2'd0) |-> $past(o_res_strobe))
        else $error("corner emitted without its predecessor");

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && !o_res.run_last) |=> o_res_strobe)
        else $error("vertex run ended without run_last");

    a_cnt_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt == 3'd3 || r_cnt == 3'd6))
        else $error("emitter holds an impossible vertex count");

endmodule

/* src/tpc_div.sv */
// Pipelined restoring divider for the crossing ratio, one quotient bit a stage.
// Depends on tpc_pkg.
module tpc_div #(
    parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DF
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [tpc_pkg::NUM_W-1:0] i_num,
    input  logic [tpc_pkg::DEN_W-1:0] i_den,
    output logic [FRAC_BITS-1:0]      o_t
);
    import tpc_pkg::*;

    logic [REM_W-1:0]     r_rem [FRAC_BITS];
    logic [DEN_W-1:0]     r_den [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_quo [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_sat;

    for (genvar g = 0; g < FRAC_BITS; g++) begin : g_stage
        logic [REM_W-1:0]     rem_in;
        logic [DEN_W-1:0]     den_in;
        logic [FRAC_BITS-1:0] quo_in;
        logic                 sat_in;
        logic [REM_W-1:0]     sh;
        logic [REM_W-1:0]     n_rem;
        logic                 bit_q;

        if (g == 0) begin : g_first
            assign rem_in = REM_W'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
            // A ratio of one or more (including a zero divisor) saturates.
            assign sat_in = (DEN_W'(i_num) >= i_den);
        end else begin : g_rest
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign quo_in = r_quo[g-1];
            assign sat_in = r_sat[g-1];
        end

        always_comb begin
            sh    = {rem_in[REM_W-2:0], 1'b0};
            bit_q = (sh >= REM_W'(den_in));
            n_rem = bit_q ? (sh - REM_W'(den_in)) : sh;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_den[g] <= den_in;
                r_quo[g] <= {quo_in[FRAC_BITS-2:0], bit_q};
                r_sat[g] <= sat_in;
            end
        end
    end

    assign o_t = r_sat[FRAC_BITS-1] ? '1 : r_quo[FRAC_BITS-1];

endmodule

/* tb/tb_triangle_plane_clipper.sv */
// Self-checking testbench of the triangle plane clipper: clip-plane predictor and scoreboard.
// Depends on tpc_pkg and triangle_plane_clipper.
module tb_triangle_plane_clipper;
    timeunit 1ns;
    timeprecision 1ps;
    import tpc_pkg::*;

    localparam int FB = FRAC_BITS_DF;
    localparam int LATENCY = FB + 12;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [PADDR_W-1:0] ADDR_AXIS = PADDR_W'(4 * REG_CLIP_AXIS);
    localparam logic [PADDR_W-1:0] ADDR_SIDE = PADDR_W'(4 * REG_PLANE_SIDE);
    localparam logic [1:0] AXIS_Z = 2'd2;

    logic i_clk, i_rst_n, start, busy, o_res_strobe;
    t_tri i_tri;
    t_res o_res;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    logic [1:0] axis_sel;
    logic side_sel;
    t_res expected_vertices[$];
    int errors;
    longint cycles;
    bit gaps_on;

    triangle_plane_clipper u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_tri(i_tri),
        .o_res_strobe(o_res_strobe), .o_res(o_res), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("%0t timeout", $time);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic t_vtx vtx_of(input t_tri t, input int i);
        t_vtx v;
        case (i)
            0:       v = '{t.vertex0_x, t.vertex0_y, t.vertex0_z, t.vertex0_w};
            1:       v = '{t.vertex1_x, t.vertex1_y, t.vertex1_z, t.vertex1_w};
            default: v = '{t.vertex2_x, t.vertex2_y, t.vertex2_z, t.vertex2_w};
        endcase
        return v;
    endfunction

    function automatic longint plane_distance(input t_vtx v);
        longint c, w;
        case (axis_sel)
            AXIS_X:  c = v.x;
            AXIS_Y:  c = v.y;
            default: c = v.z;
        endcase
        w = v.w;
        return side_sel ? c - w : c + w;
    endfunction

    function automatic bit beyond_plane(input t_vtx v);
        longint d;
        d = plane_distance(v);
        return side_sel ? d > 0 : d < 0;
    endfunction

    // Crossing fraction from outside vertex p toward inside vertex q, truncated.
    function automatic longint cross_fraction(input t_vtx p, input t_vtx q);
        longint d1, dd, num, den;
        d1 = plane_distance(p);
        dd = d1 - plane_distance(q);
        num = d1 < 0 ? -d1 : d1;
        den = dd < 0 ? -dd : dd;
        if (den == 0 || num >= den) return (longint'(1) << FB) - 1;
        return (num << FB) / den;
    endfunction

    function automatic t_coord lerp_coord(input longint p, input longint q, input longint t);
        longint diff, lo, hi, r;
        diff = q - p;
        lo = diff & ((longint'(1) << FB) - 1);
        hi = (diff - lo) >>> FB;
        r = p + hi * t + ((lo * t) >>> FB);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return t_coord'(r);
    endfunction

    function automatic t_vtx crossing(input t_vtx p, input t_vtx q);
        longint t;
        t_vtx r;
        t = cross_fraction(p, q);
        r.x = lerp_coord(p.x, q.x, t);
        r.y = lerp_coord(p.y, q.y, t);
        r.z = lerp_coord(p.z, q.z, t);
        r.w = lerp_coord(p.w, q.w, t);
        return r;
    endfunction

    task automatic queue_triangle(input t_vtx a, input t_vtx b, input t_vtx c);
        t_vtx v[3];
        t_res item;
        v = '{a, b, c};
        for (int k = 0; k < 3; k++) begin
            item = '{v[k].x, v[k].y, v[k].z, v[k].w, 2'(k), 1'b0};
            expected_vertices = {expected_vertices, item};
        end
    endtask

    task automatic predict_clip(input t_tri t);
        t_vtx v[3];
        int ins[3], outs[3];
        int ni, no;
        t_vtx a1, c1;
        ni = 0;
        no = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = vtx_of(t, i);
            if (beyond_plane(v[i])) outs[no++] = i;
            else ins[ni++] = i;
        end
        if (ni == 3) begin
            queue_triangle(v[0], v[1], v[2]);
        end else if (ni == 1) begin
            a1 = crossing(v[outs[0]], v[ins[0]]);
            c1 = crossing(v[outs[1]], v[ins[0]]);
            if ((ins[0] + 1) % 3 == outs[0]) queue_triangle(v[ins[0]], a1, c1);
            else queue_triangle(v[ins[0]], c1, a1);
        end else if (ni == 2) begin
            a1 = crossing(v[outs[0]], v[ins[0]]);
            c1 = crossing(v[outs[0]], v[ins[1]]);
            if ((ins[0] + 1) % 3 == outs[0]) begin
                queue_triangle(v[ins[0]], a1, c1);
                queue_triangle(v[ins[0]], c1, v[ins[1]]);
            end else begin
                queue_triangle(v[ins[0]], v[ins[1]], c1);
                queue_triangle(v[ins[0]], c1, a1);
            end
        end
        if (ni > 0) begin
            expected_vertices[expected_vertices.size() - 1].run_last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_strobe) begin
            if (expected_vertices.size() == 0) begin
                $display("%0t unexpected vertex: expected none, actual %p", $time, o_res);
                errors++;
            end else begin
                want = expected_vertices.pop_front();
                if (o_res.out_x !== want.out_x)
                    $display("%0t out_x expected %h actual %h", $time, want.out_x, o_res.out_x);
                if (o_res.out_y !== want.out_y)
                    $display("%0t out_y expected %h actual %h", $time, want.out_y, o_res.out_y);
                if (o_res.out_z !== want.out_z)
                    $display("%0t out_z expected %h actual %h", $time, want.out_z, o_res.out_z);
                if (o_res.out_w !== want.out_w)
                    $display("%0t out_w expected %h actual %h", $time, want.out_w, o_res.out_w);
                if (o_res.corner_slot !== want.corner_slot)
                    $display("%0t corner_slot expected %0d actual %0d", $time,
                             want.corner_slot, o_res.corner_slot);
                if (o_res.run_last !== want.run_last)
                    $display("%0t run_last expected %0d actual %0d", $time,
                             want.run_last, o_res.run_last);
                if (o_res !== want) errors++;
            end
        end
    end

    task automatic send_triangle(input t_tri t);
        if (gaps_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        start = 1'b1;
        i_tri = t;
        do @(posedge i_clk); while (busy);
        predict_clip(t);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic drain_results();
        while (expected_vertices.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_AXIS) axis_sel = data[1:0];
        else if (addr == ADDR_SIDE) side_sel = data[0];
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_plane(input logic [31:0] axis, input logic [31:0] side);
        drain_results();
        write_register(ADDR_AXIS, axis);
        write_register(ADDR_SIDE, side);
    endtask

    function automatic t_coord small_coord();
        return t_coord'($urandom_range(0, 32'h0008_0000)) - t_coord'(32'h0004_0000);
    endfunction

    function automatic t_coord any_coord();
        case ($urandom_range(0, 5))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return t_coord'($urandom);
            default: return small_coord();
        endcase
    endfunction

    function automatic t_tri random_triangle(input bit wild);
        t_tri t;
        t = '{default: '0};
        t.vertex0_x = wild ? any_coord() : small_coord();
        t.vertex0_y = wild ? any_coord() : small_coord();
        t.vertex0_z = wild ? any_coord() : small_coord();
        t.vertex0_w = wild ? any_coord() : small_coord();
        t.vertex1_x = wild ? any_coord() : small_coord();
        t.vertex1_y = wild ? any_coord() : small_coord();
        t.vertex1_z = wild ? any_coord() : small_coord();
        t.vertex1_w = wild ? any_coord() : small_coord();
        t.vertex2_x = wild ? any_coord() : small_coord();
        t.vertex2_y = wild ? any_coord() : small_coord();
        t.vertex2_z = wild ? any_coord() : small_coord();
        t.vertex2_w = wild ? any_coord() : small_coord();
        return t;
    endfunction

    // Vertices given as z,w pairs; x and y equal z so every axis sees the same case.
    function automatic t_tri zw_triangle(input t_coord z0, w0, z1, w1, z2, w2);
        return '{z0, z0, z0, w0, z1, z1, z1, w1, z2, z2, z2, w2};
    endfunction

    task automatic test_reset_plane();
        // Reset plane is z = -w; all inside with one on the plane, all outside, all inside with one on the plane.
        send_triangle(zw_triangle(32'h1_0000, 32'h2_0000, 32'h0, 32'h1_0000, -32'sh1_0000,
                                  32'h1_0000));
        send_triangle(zw_triangle(-32'sh2_0000, 32'h1_0000, -32'sh3_0000, 32'h1_0000,
                                  -32'sh4_0000, 32'h2_0000));
        send_triangle(zw_triangle(-32'sh1_0000, 32'h1_0000, 32'h0, 32'h1_0000, 32'h0,
                                  32'h1_0000));
    endtask

    task automatic test_winding_cases();
        for (int axis = 0; axis < 4; axis++) begin
            for (int side = 0; side < 2; side++) begin
                set_plane(axis, side == 0 ? 32'hffff_fffe : 32'hffff_ffff);
                // Each pattern puts the outside vertices at different corners.
                for (int pat = 1; pat < 7; pat++) begin
                    t_coord z[3];
                    for (int i = 0; i < 3; i++) begin
                        z[i] = pat[i] ? 32'h3_0000 : 32'h0_8000;
                        if (side == 0) z[i] = -z[i];
                    end
                    send_triangle(zw_triangle(z[0], 32'h1_0000, z[1], 32'h1_0000,
                                              z[2], 32'h1_0000));
                end
            end
        end
    endtask

    task automatic test_extremes();
        t_tri t;
        set_plane(AXIS_Z, 1);
        t = '{default: 32'h7fff_ffff};
        send_triangle(t);
        t = '{default: 32'h8000_0000};
        send_triangle(t);
        send_triangle(zw_triangle(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                  32'h0, 32'h0));
        send_triangle(zw_triangle(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                  32'h7fff_ffff, 32'h8000_0000));
        // Addresses wrap at the port width, so these writes land on the plane registers.
        drain_results();
        write_register(PADDR_W'(8), 32'hffff_ffff);
        write_register(PADDR_W'(12), 32'h0);
        send_triangle(zw_triangle(32'h3_0000, 32'h1_0000, 32'h0, 32'h1_0000, 32'h0,
                                  32'h1_0000));
    endtask

    task automatic test_random_planes(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) set_plane($urandom, $urandom);
            send_triangle(random_triangle($urandom_range(0, 3) == 0));
        end
    endtask

    task automatic test_pause_until_idle();
        drain_results();
        send_triangle(random_triangle(1'b0));
        drain_results();
    endtask

    initial begin
        errors = 0;
        gaps_on = 1'b0;
        axis_sel = AXIS_Z;
        side_sel = 1'b0;
        start = 1'b0;
        i_tri = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_plane();
        test_winding_cases();
        test_extremes();
        gaps_on = 1'b1;
        test_random_planes(300);
        test_pause_until_idle();
        gaps_on = 1'b0;
        test_random_planes(200);
        drain_results();
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
